// ===== hdl/aff3_pkg.sv =====
package aff3_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // field and datapath widths
    localparam int M_W     = 32;   // matrix entry
    localparam int P_W     = 64;   // entry product
    localparam int C_W     = 65;   // cofactor, axis dot product
    localparam int DET_W   = 99;   // determinant and its partial sums
    localparam int DEN_W   = 97;   // divisor magnitude
    localparam int Q_W     = 33;   // quotient bits, top bit flags overflow
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 2;
    localparam int N_ENT   = 9;
    localparam int N_PROD  = 26;

    // register indexes
    localparam logic [CFG_A_W-1:0] CFG_ZERO_TOL   = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_AXIS_FLOOR = 2'd1;

    typedef enum logic [1:0] {
        PATH_INV   = 2'd0,
        PATH_XAXIS = 2'd1,
        PATH_YAXIS = 2'd2,
        PATH_ZERO  = 2'd3
    } t_path;

    typedef enum logic [1:0] {
        LANE_DIV  = 2'd0,
        LANE_ZERO = 2'd1,
        LANE_ONE  = 2'd2
    } t_lane;

    // operand pairs of the first multiplier bank: 18 for the cofactors,
    // then the x axis (len, dot) and the y axis (len, dot)
    localparam int PROD_A [N_PROD] = '{4, 5, 1, 2, 1, 2, 3, 5, 0, 2, 0, 2, 3, 4, 0, 1, 0, 1,
                                       0, 1, 6, 7, 3, 4, 6, 7};
    localparam int PROD_B [N_PROD] = '{8, 7, 8, 7, 5, 4, 8, 6, 8, 6, 5, 3, 7, 6, 7, 6, 4, 3,
                                       0, 1, 0, 1, 3, 4, 3, 4};

    typedef struct packed {
        logic [4:0][M_W-1:0]       m;
        logic [N_ENT-1:0][C_W-1:0] c;
        logic [P_W-1:0]            len_x;
        logic [P_W-1:0]            len_y;
        logic [C_W-1:0]            t_x;
        logic [C_W-1:0]            t_y;
        logic                      near_x;
        logic                      near_y;
    } t_mid;

    function automatic logic f_near(input logic signed [M_W:0] d,
                                    input logic [CFG_W-1:0] tol);
        logic [M_W:0] a;
        a = d[M_W] ? -d : d;
        return a < (M_W+1)'(tol);
    endfunction

    function automatic logic [C_W-1:0] f_abs_c(input logic [C_W-1:0] v);
        return v[C_W-1] ? -v : v;
    endfunction

    function automatic logic [M_W:0] f_abs_m(input logic [M_W-1:0] v);
        logic [M_W:0] x;
        x = {v[M_W-1], v};
        return x[M_W] ? -x : x;
    endfunction

endpackage

// ===== hdl/affine3_matrix_inverse.sv =====
// 3x3 fixed-point matrix inverse. One matrix item enters per clock; the
// pipeline has 42 register stages
// (products, cofactors, determinant, path select, one stage per bit of a
// 33-step restoring divider, rounding, saturation) and bubbles close up
// under output stalls, so input is refused only when every stage is full.
// The regular path is adjugate / determinant with nine dividers in parallel;
// a determinant within zero_tolerance of zero falls back to an x-axis or
// y-axis back transform that reuses three of those dividers, or else to an
// all-zero matrix. path_taken reports which: 0 inverse, 1 x axis, 2 y axis,
// 3 zero. Results are rounded to nearest (ties away) and saturated.
// Configuration must only be written while the pipeline is empty.
module affine3_matrix_inverse #(
    parameter int FRAC_BITS = aff3_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [aff3_pkg::CFG_A_W-1:0]          i_cfg_idx,
    input  logic [aff3_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [aff3_pkg::M_W-1:0]       i_a_r0c0,
    input  logic signed [aff3_pkg::M_W-1:0]       i_a_r0c1,
    input  logic signed [aff3_pkg::M_W-1:0]       i_a_r0c2,
    input  logic signed [aff3_pkg::M_W-1:0]       i_a_r1c0,
    input  logic signed [aff3_pkg::M_W-1:0]       i_a_r1c1,
    input  logic signed [aff3_pkg::M_W-1:0]       i_a_r1c2,
    input  logic signed [aff3_pkg::M_W-1:0]       i_a_r2c0,
    input  logic signed [aff3_pkg::M_W-1:0]       i_a_r2c1,
    input  logic signed [aff3_pkg::M_W-1:0]       i_a_r2c2,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [aff3_pkg::M_W-1:0]       o_b_r0c0,
    output logic signed [aff3_pkg::M_W-1:0]       o_b_r0c1,
    output logic signed [aff3_pkg::M_W-1:0]       o_b_r0c2,
    output logic signed [aff3_pkg::M_W-1:0]       o_b_r1c0,
    output logic signed [aff3_pkg::M_W-1:0]       o_b_r1c1,
    output logic signed [aff3_pkg::M_W-1:0]       o_b_r1c2,
    output logic signed [aff3_pkg::M_W-1:0]       o_b_r2c0,
    output logic signed [aff3_pkg::M_W-1:0]       o_b_r2c1,
    output logic signed [aff3_pkg::M_W-1:0]       o_b_r2c2,
    output logic [1:0]                            o_path_taken
);
    import aff3_pkg::*;

    // numerator magnitude: cofactor shifted by two fraction widths
    localparam int NUM_W = C_W + 2*FRAC_BITS;
    // compare width for one divider step
    localparam int RW_A  = DEN_W + Q_W - 1;
    localparam int RW    = ((NUM_W > RW_A) ? NUM_W : RW_A) + 1;

    // stage numbering
    localparam int ST_PROD = 1;
    localparam int ST_COF  = 2;
    localparam int ST_PART = 3;
    localparam int ST_TERM = 4;
    localparam int ST_DET  = 5;
    localparam int ST_PATH = 6;
    localparam int ST_LANE = 7;
    localparam int ST_RND  = ST_LANE + Q_W + 1;
    localparam int ST_OUT  = ST_RND + 1;
    localparam int NST     = ST_OUT;

    localparam logic signed [M_W-1:0] L_ONE = M_W'(1) << FRAC_BITS;

    // config registers
    logic [CFG_W-1:0] r_zero_tol;
    logic [CFG_W-1:0] r_axis_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_tol   <= CFG_W'(1);
            r_axis_floor <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZERO_TOL:   r_zero_tol   <= i_cfg_data;
                CFG_AXIS_FLOOR: r_axis_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain; a stage may load when it or any stage after it is empty
    logic [NST:1]   r_vld;
    logic [NST+1:1] w_en;

    assign w_en[NST+1] = i_out_ready;
    for (genvar k = 1; k <= NST; k++) begin : g_en
        assign w_en[k] = i_out_ready | ~(&r_vld[NST:k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_en[1];
    assign o_out_valid = r_vld[NST];

    // stage 1: all entry products, near-zero tests
    logic signed [M_W-1:0] w_m [N_ENT];
    assign w_m[0] = i_a_r0c0;
    assign w_m[1] = i_a_r0c1;
    assign w_m[2] = i_a_r0c2;
    assign w_m[3] = i_a_r1c0;
    assign w_m[4] = i_a_r1c1;
    assign w_m[5] = i_a_r1c2;
    assign w_m[6] = i_a_r2c0;
    assign w_m[7] = i_a_r2c1;
    assign w_m[8] = i_a_r2c2;

    logic signed [P_W-1:0] r_s1_pr [N_PROD];
    logic [4:0][M_W-1:0]   r_s1_m;
    logic                  r_s1_near_x;
    logic                  r_s1_near_y;
    logic                  w_near [N_ENT];
    logic                  w_near_one;

    always_comb begin
        for (int i = 0; i < N_ENT; i++) begin
            w_near[i] = f_near((M_W+1)'(w_m[i]), r_zero_tol);
        end
        w_near_one = f_near((M_W+1)'(w_m[8]) - (M_W+1)'(L_ONE), r_zero_tol);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PROD]) begin
            for (int j = 0; j < N_PROD; j++) begin
                r_s1_pr[j] <= w_m[PROD_A[j]] * w_m[PROD_B[j]];
            end
            for (int i = 0; i < 5; i++) begin
                r_s1_m[i] <= w_m[i];
            end
            r_s1_near_x <= w_near[2] & w_near[3] & w_near[4] & w_near[5] & w_near_one;
            r_s1_near_y <= w_near[0] & w_near[1] & w_near[2] & w_near[5] & w_near_one;
        end
    end

    // stage 2: cofactors (adjugate in place), axis lengths and dot products
    t_mid r_s2_mid;

    function automatic logic [C_W-1:0] f_dif(input logic signed [P_W-1:0] a,
                                             input logic signed [P_W-1:0] b);
        return C_W'(a) - C_W'(b);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en[ST_COF]) begin
            r_s2_mid.m      <= r_s1_m;
            r_s2_mid.c[0]   <= f_dif(r_s1_pr[0],  r_s1_pr[1]);
            r_s2_mid.c[1]   <= f_dif(r_s1_pr[3],  r_s1_pr[2]);
            r_s2_mid.c[2]   <= f_dif(r_s1_pr[4],  r_s1_pr[5]);
            r_s2_mid.c[3]   <= f_dif(r_s1_pr[7],  r_s1_pr[6]);
            r_s2_mid.c[4]   <= f_dif(r_s1_pr[8],  r_s1_pr[9]);
            r_s2_mid.c[5]   <= f_dif(r_s1_pr[11], r_s1_pr[10]);
            r_s2_mid.c[6]   <= f_dif(r_s1_pr[12], r_s1_pr[13]);
            r_s2_mid.c[7]   <= f_dif(r_s1_pr[15], r_s1_pr[14]);
            r_s2_mid.c[8]   <= f_dif(r_s1_pr[16], r_s1_pr[17]);
            r_s2_mid.len_x  <= r_s1_pr[18] + r_s1_pr[19];
            r_s2_mid.t_x    <= C_W'(r_s1_pr[20]) + C_W'(r_s1_pr[21]);
            r_s2_mid.len_y  <= r_s1_pr[22] + r_s1_pr[23];
            r_s2_mid.t_y    <= C_W'(r_s1_pr[24]) + C_W'(r_s1_pr[25]);
            r_s2_mid.near_x <= r_s1_near_x;
            r_s2_mid.near_y <= r_s1_near_y;
        end
    end

    // stage 3: determinant partial products, cofactor split at bit M_W
    logic signed [C_W-1:0] r_s3_lo [3];
    logic signed [C_W-1:0] r_s3_hi [3];
    t_mid                  r_s3_mid;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PART]) begin
            for (int j = 0; j < 3; j++) begin
                r_s3_lo[j] <= $signed(r_s2_mid.m[j])
                            * $signed({1'b0, r_s2_mid.c[3*j][M_W-1:0]});
                r_s3_hi[j] <= $signed(r_s2_mid.m[j])
                            * $signed(r_s2_mid.c[3*j][C_W-1:M_W]);
            end
            r_s3_mid <= r_s2_mid;
        end
    end

    // stage 4: recombine each term
    logic signed [DET_W-1:0] r_s4_term [3];
    t_mid                    r_s4_mid;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_TERM]) begin
            for (int j = 0; j < 3; j++) begin
                r_s4_term[j] <= (DET_W'(r_s3_hi[j]) <<< M_W) + DET_W'(r_s3_lo[j]);
            end
            r_s4_mid <= r_s3_mid;
        end
    end

    // stage 5: determinant
    logic signed [DET_W-1:0] r_s5_det;
    t_mid                    r_s5_mid;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DET]) begin
            r_s5_det <= r_s4_term[0] + r_s4_term[1] + r_s4_term[2];
            r_s5_mid <= r_s4_mid;
        end
    end

    // stage 6: pick the path
    logic signed [DET_W-1:0] w_tol_pos;
    logic signed [DET_W-1:0] w_tol_neg;
    logic [P_W-1:0]          w_floor;
    logic                    w_regular;
    logic                    w_fb_x;
    logic                    w_fb_y;
    t_path                   w_path;

    logic [DEN_W-1:0] r_s6_det_abs;
    logic             r_s6_det_neg;
    t_path            r_s6_path;
    t_mid             r_s6_mid;

    always_comb begin
        w_tol_pos = DET_W'(r_zero_tol) <<< (2*FRAC_BITS);
        w_tol_neg = -w_tol_pos;
        w_floor   = P_W'(r_axis_floor) << FRAC_BITS;
        w_regular = (r_s5_det != '0) && ((r_s5_det >= w_tol_pos) || (r_s5_det <= w_tol_neg));
        w_fb_x    = r_s5_mid.near_x && (r_s5_mid.len_x > w_floor);
        w_fb_y    = r_s5_mid.near_y && (r_s5_mid.len_y > w_floor);
        if (w_regular) begin
            w_path = PATH_INV;
        end else if (w_fb_x) begin
            w_path = PATH_XAXIS;
        end else if (w_fb_y) begin
            w_path = PATH_YAXIS;
        end else begin
            w_path = PATH_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PATH]) begin
            r_s6_det_abs <= DEN_W'(r_s5_det[DET_W-1] ? -r_s5_det : r_s5_det);
            r_s6_det_neg <= r_s5_det[DET_W-1];
            r_s6_path    <= w_path;
            r_s6_mid     <= r_s5_mid;
        end
    end

    // divider pipeline storage; index 0 is loaded by the lane set-up stage
    logic [NUM_W-1:0]        r_dv_rem  [Q_W+1][N_ENT];
    logic [Q_W-1:0]          r_dv_q    [Q_W+1][N_ENT];
    logic [DEN_W-1:0]        r_dv_den  [Q_W+1];
    logic [N_ENT-1:0]        r_dv_neg  [Q_W+1];
    t_lane [N_ENT-1:0]       r_dv_kind [Q_W+1];
    t_path                   r_dv_path [Q_W+1];

    // stage 7: route numerators and divisor into the nine lanes
    logic [NUM_W-1:0]  n_num [N_ENT];
    logic [N_ENT-1:0]  n_neg;
    t_lane [N_ENT-1:0] n_kind;
    logic [DEN_W-1:0]  n_den;

    always_comb begin
        for (int l = 0; l < N_ENT; l++) begin
            n_num[l]  = '0;
            n_kind[l] = LANE_ZERO;
        end
        n_neg = '0;
        n_den = '0;
        case (r_s6_path)
            PATH_INV: begin
                n_den = r_s6_det_abs;
                for (int l = 0; l < N_ENT; l++) begin
                    n_num[l]  = NUM_W'(f_abs_c(r_s6_mid.c[l])) << (2*FRAC_BITS);
                    n_neg[l]  = r_s6_mid.c[l][C_W-1] ^ r_s6_det_neg;
                    n_kind[l] = LANE_DIV;
                end
            end
            PATH_XAXIS: begin
                n_den     = DEN_W'(r_s6_mid.len_x);
                n_num[0]  = NUM_W'(f_abs_m(r_s6_mid.m[0])) << (2*FRAC_BITS);
                n_neg[0]  = r_s6_mid.m[0][M_W-1];
                n_kind[0] = LANE_DIV;
                n_num[3]  = NUM_W'(f_abs_m(r_s6_mid.m[1])) << (2*FRAC_BITS);
                n_neg[3]  = r_s6_mid.m[1][M_W-1];
                n_kind[3] = LANE_DIV;
                // back translation is minus the dot product
                n_num[6]  = NUM_W'(f_abs_c(r_s6_mid.t_x)) << FRAC_BITS;
                n_neg[6]  = ~r_s6_mid.t_x[C_W-1];
                n_kind[6] = LANE_DIV;
                n_kind[8] = LANE_ONE;
            end
            PATH_YAXIS: begin
                n_den     = DEN_W'(r_s6_mid.len_y);
                n_num[1]  = NUM_W'(f_abs_m(r_s6_mid.m[3])) << (2*FRAC_BITS);
                n_neg[1]  = r_s6_mid.m[3][M_W-1];
                n_kind[1] = LANE_DIV;
                n_num[4]  = NUM_W'(f_abs_m(r_s6_mid.m[4])) << (2*FRAC_BITS);
                n_neg[4]  = r_s6_mid.m[4][M_W-1];
                n_kind[4] = LANE_DIV;
                n_num[7]  = NUM_W'(f_abs_c(r_s6_mid.t_y)) << FRAC_BITS;
                n_neg[7]  = ~r_s6_mid.t_y[C_W-1];
                n_kind[7] = LANE_DIV;
                n_kind[8] = LANE_ONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_LANE]) begin
            for (int l = 0; l < N_ENT; l++) begin
                r_dv_rem[0][l] <= n_num[l];
                r_dv_q[0][l]   <= '0;
            end
            r_dv_den[0]  <= n_den;
            r_dv_neg[0]  <= n_neg;
            r_dv_kind[0] <= n_kind;
            r_dv_path[0] <= r_s6_path;
        end
    end

    // restoring divider, one quotient bit per stage, msb first;
    // the first bit set means the quotient does not fit and will saturate
    for (genvar s = 1; s <= Q_W; s++) begin : g_div
        localparam int SH = Q_W - s;

        for (genvar l = 0; l < N_ENT; l++) begin : g_lane
            logic [RW-1:0] w_rem_x;
            logic [RW-1:0] w_den_x;
            logic          w_ge;

            assign w_rem_x = RW'(r_dv_rem[s-1][l]);
            assign w_den_x = RW'(r_dv_den[s-1]) << SH;
            assign w_ge    = (w_rem_x >= w_den_x);

            always_ff @(posedge i_clk) begin
                if (w_en[ST_LANE+s]) begin
                    r_dv_rem[s][l] <= w_ge ? NUM_W'(w_rem_x - w_den_x) : r_dv_rem[s-1][l];
                    r_dv_q[s][l]   <= {r_dv_q[s-1][l][Q_W-2:0], w_ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[ST_LANE+s]) begin
                r_dv_den[s]  <= r_dv_den[s-1];
                r_dv_neg[s]  <= r_dv_neg[s-1];
                r_dv_kind[s] <= r_dv_kind[s-1];
                r_dv_path[s] <= r_dv_path[s-1];
            end
        end
    end

    // rounding: bump when the remainder is at least half the divisor
    logic [Q_W-1:0]    r_rn_mag [N_ENT];
    logic [N_ENT-1:0]  r_rn_ovf;
    logic [N_ENT-1:0]  r_rn_neg;
    t_lane [N_ENT-1:0] r_rn_kind;
    t_path             r_rn_path;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_RND]) begin
            for (int l = 0; l < N_ENT; l++) begin
                r_rn_mag[l] <= {1'b0, r_dv_q[Q_W][l][Q_W-2:0]}
                             + Q_W'((RW'(r_dv_rem[Q_W][l]) << 1) >= RW'(r_dv_den[Q_W]));
                r_rn_ovf[l] <= r_dv_q[Q_W][l][Q_W-1];
            end
            r_rn_neg  <= r_dv_neg[Q_W];
            r_rn_kind <= r_dv_kind[Q_W];
            r_rn_path <= r_dv_path[Q_W];
        end
    end

    // sign, saturation and constant entries into the output register
    localparam logic [Q_W-1:0] L_POS_MAX = Q_W'({1'b0, {(M_W-1){1'b1}}});
    localparam logic [Q_W-1:0] L_NEG_MAX = Q_W'({1'b1, {(M_W-1){1'b0}}});

    logic signed [M_W-1:0] n_out [N_ENT];
    logic signed [M_W-1:0] r_out [N_ENT];
    t_path                 r_out_path;

    always_comb begin
        for (int l = 0; l < N_ENT; l++) begin
            case (r_rn_kind[l])
                LANE_DIV: begin
                    if (r_rn_neg[l]) begin
                        n_out[l] = (r_rn_ovf[l] || (r_rn_mag[l] > L_NEG_MAX))
                                 ? $signed(L_NEG_MAX[M_W-1:0])
                                 : -$signed(r_rn_mag[l][M_W-1:0]);
                    end else begin
                        n_out[l] = (r_rn_ovf[l] || (r_rn_mag[l] > L_POS_MAX))
                                 ? $signed(L_POS_MAX[M_W-1:0])
                                 : $signed(r_rn_mag[l][M_W-1:0]);
                    end
                end
                LANE_ONE:  n_out[l] = L_ONE;
                default:   n_out[l] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            for (int l = 0; l < N_ENT; l++) begin
                r_out[l] <= n_out[l];
            end
            r_out_path <= r_rn_path;
        end
    end

    assign o_b_r0c0     = r_out[0];
    assign o_b_r0c1     = r_out[1];
    assign o_b_r0c2     = r_out[2];
    assign o_b_r1c0     = r_out[3];
    assign o_b_r1c1     = r_out[4];
    assign o_b_r1c2     = r_out[5];
    assign o_b_r2c0     = r_out[6];
    assign o_b_r2c1     = r_out[7];
    assign o_b_r2c2     = r_out[8];
    assign o_path_taken = r_out_path;

endmodule

// ===== test/affine3_matrix_inverse_test.sv =====
module affine3_matrix_inverse_test;
    timeunit 1ns;
    timeprecision 1ps;

    import aff3_pkg::*;

    localparam int ONE       = 32'h0001_0000;
    localparam int LIMIT     = 400000;
    localparam int N_RANDOM  = 88;        // random items per configuration phase
    localparam int LONG_HOLD = 1500;      // receiver hold-off, long enough to fill every stage

    // wide enough for cofactor * entry shifted by 32 with margin
    typedef logic signed [255:0] t_wide;
    typedef logic [8:0][31:0] t_mat;

    typedef struct packed {
        logic [8:0][31:0] b;
        t_path            path;
    } t_inverse;

    typedef struct packed {
        t_mat     m;
        logic     typed;
        t_inverse exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [8:0][31:0] a_drv = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic signed [31:0] o_b [9];
    logic [1:0]  o_path_taken;

    // predictor copy of the two registers
    int unsigned zero_tol_q = 1;
    int unsigned axis_floor_q = 1;

    t_inverse inverse_q[$];    // expected result items, oldest first
    int       mismatches = 0;
    int       rx_count = 0;
    int       cycle_count = 0;
    t_row     directed[$];

    string field_name [9] = '{"b_r0c0", "b_r0c1", "b_r0c2", "b_r1c0", "b_r1c1",
                              "b_r1c2", "b_r2c0", "b_r2c1", "b_r2c2"};

    affine3_matrix_inverse i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_a_r0c0    (a_drv[0]),
        .i_a_r0c1    (a_drv[1]),
        .i_a_r0c2    (a_drv[2]),
        .i_a_r1c0    (a_drv[3]),
        .i_a_r1c1    (a_drv[4]),
        .i_a_r1c2    (a_drv[5]),
        .i_a_r2c0    (a_drv[6]),
        .i_a_r2c1    (a_drv[7]),
        .i_a_r2c2    (a_drv[8]),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_b_r0c0    (o_b[0]),
        .o_b_r0c1    (o_b[1]),
        .o_b_r0c2    (o_b[2]),
        .o_b_r1c0    (o_b[3]),
        .o_b_r1c1    (o_b[4]),
        .o_b_r1c2    (o_b[5]),
        .o_b_r2c0    (o_b[6]),
        .o_b_r2c1    (o_b[7]),
        .o_b_r2c2    (o_b[8]),
        .o_path_taken(o_path_taken)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("affine3_matrix_inverse_test failed");
            $finish;
        end
    end

    function automatic t_mat mat(input int a0, a1, a2, a3, a4, a5, a6, a7, a8);
        t_mat r;
        r[0] = a0; r[1] = a1; r[2] = a2;
        r[3] = a3; r[4] = a4; r[5] = a5;
        r[6] = a6; r[7] = a7; r[8] = a8;
        return r;
    endfunction

    // num / den rounded to nearest with ties away from zero, saturated
    function automatic logic [31:0] round_div(input t_wide num, input t_wide den);
        t_wide n, d, q, r;
        logic  neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n % d;
        if (2 * r >= d) q = q + 1;
        if (neg) begin
            if (q > t_wide'(64'h8000_0000)) return 32'h8000_0000;
            return 32'(-q);
        end
        if (q > t_wide'(64'h7FFF_FFFF)) return 32'h7FFF_FFFF;
        return 32'(q);
    endfunction

    function automatic logic close_to(input t_wide x, input t_wide y);
        t_wide d;
        d = x - y;
        if (d < 0) d = -d;
        return d < t_wide'(zero_tol_q);
    endfunction

    function automatic t_inverse invert(input t_mat a);
        t_wide    m [9];
        t_wide    c [9];
        t_wide    det, adet, len, dot, floor_w;
        t_inverse r;
        for (int i = 0; i < 9; i++) m[i] = $signed(a[i]);
        r = '0;
        c[0] =   m[4] * m[8] - m[5] * m[7];
        c[1] = -(m[1] * m[8] - m[2] * m[7]);
        c[2] =   m[1] * m[5] - m[2] * m[4];
        c[3] = -(m[3] * m[8] - m[5] * m[6]);
        c[4] =   m[0] * m[8] - m[2] * m[6];
        c[5] = -(m[0] * m[5] - m[2] * m[3]);
        c[6] =   m[3] * m[7] - m[4] * m[6];
        c[7] = -(m[0] * m[7] - m[1] * m[6]);
        c[8] =   m[0] * m[4] - m[1] * m[3];
        det  = m[0] * c[0] + m[1] * c[3] + m[2] * c[6];
        adet = (det < 0) ? -det : det;
        if (det != 0 && adet >= (t_wide'(zero_tol_q) <<< 32)) begin
            for (int i = 0; i < 9; i++) r.b[i] = round_div(c[i] <<< 32, det);
            r.path = PATH_INV;
            return r;
        end
        floor_w = t_wide'(axis_floor_q) <<< 16;
        // x axis only map
        if (close_to(m[2], 0) && close_to(m[3], 0) && close_to(m[4], 0) &&
            close_to(m[5], 0) && close_to(m[8], ONE)) begin
            len = m[0] * m[0] + m[1] * m[1];
            if (len > floor_w) begin
                dot = m[6] * m[0] + m[7] * m[1];
                r.b[0] = round_div(m[0] <<< 32, len);
                r.b[3] = round_div(m[1] <<< 32, len);
                r.b[6] = round_div((-dot) <<< 16, len);
                r.b[8] = ONE;
                r.path = PATH_XAXIS;
                return r;
            end
        end
        // y axis only map
        if (close_to(m[0], 0) && close_to(m[1], 0) && close_to(m[2], 0) &&
            close_to(m[5], 0) && close_to(m[8], ONE)) begin
            len = m[3] * m[3] + m[4] * m[4];
            if (len > floor_w) begin
                dot = m[6] * m[3] + m[7] * m[4];
                r.b[1] = round_div(m[3] <<< 32, len);
                r.b[4] = round_div(m[4] <<< 32, len);
                r.b[7] = round_div((-dot) <<< 16, len);
                r.b[8] = ONE;
                r.path = PATH_YAXIS;
                return r;
            end
        end
        r.path = PATH_ZERO;
        return r;
    endfunction

    // small signed deviation around the tolerance edge
    function automatic int jitter();
        int e;
        e = $urandom_range(0, zero_tol_q + 1);
        return $urandom_range(0, 1) ? -e : e;
    endfunction

    function automatic int scaled_entry();
        int sh;
        sh = $urandom_range(4, 31);
        return $urandom_range(0, 1) ? -int'($urandom % (1 << sh)) : int'($urandom % (1 << sh));
    endfunction

    function automatic int extreme_entry();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 0;
            3: return ONE;
            4: return -ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_mat random_matrix();
        t_mat r;
        case ($urandom_range(0, 9))
            0, 1: for (int i = 0; i < 9; i++) r[i] = $urandom;
            2, 3: for (int i = 0; i < 9; i++) r[i] = scaled_entry();
            4, 5: begin
                // x axis shaped, with translation
                r = mat(scaled_entry(), scaled_entry(), jitter(), jitter(), jitter(),
                        jitter(), $urandom, $urandom, ONE + jitter());
            end
            6, 7: begin
                r = mat(jitter(), jitter(), jitter(), scaled_entry(), scaled_entry(),
                        jitter(), $urandom, $urandom, ONE + jitter());
            end
            8: begin
                // singular: one row repeats another
                for (int i = 0; i < 6; i++) r[i] = scaled_entry();
                for (int i = 6; i < 9; i++) r[i] = r[i - 6];
            end
            default: for (int i = 0; i < 9; i++) r[i] = extreme_entry();
        endcase
        return r;
    endfunction

    // offer one matrix item after a random gap, wait for acceptance
    task automatic send_matrix(input t_mat m, input t_inverse exp);
        int gap;
        gap = $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        a_drv <= m;
        do @(posedge i_clk); while (!o_in_ready);
        inverse_q.push_back(exp);
    endtask

    // write one register, predictor follows
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ZERO_TOL) zero_tol_q = val;
        else if (idx == CFG_AXIS_FLOOR) axis_floor_q = val;
        @(posedge i_clk);
    endtask

    // sender holds off until every result item is back, then drains the pipe
    task automatic drain();
        i_in_valid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic random_phase();
        t_mat m;
        for (int n = 0; n < N_RANDOM; n++) begin
            m = random_matrix();
            send_matrix(m, invert(m));
        end
        drain();
    endtask

    // receiver: random stalls, one long hold-off to fill the pipeline
    initial begin
        int       stall;
        t_inverse got, exp;
        forever begin
            stall = $urandom_range(0, 18);
            if (rx_count == 60) stall = LONG_HOLD;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
            for (int i = 0; i < 9; i++) got.b[i] = o_b[i];
            got.path = t_path'(o_path_taken);
            rx_count++;
            if (inverse_q.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatches++;
            end else begin
                exp = inverse_q.pop_front();
                for (int i = 0; i < 9; i++) begin
                    if (got.b[i] !== exp.b[i]) begin
                        $error("%s expected %h actual %h", field_name[i], exp.b[i], got.b[i]);
                        mismatches++;
                    end
                end
                if (got.path !== exp.path) begin
                    $error("path_taken expected %0d actual %0d", exp.path, got.path);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_inverse ident, zero, half, neg1;
        t_inverse xhalf, yhalf;
        t_row     row;

        ident = '0;
        ident.b[0] = ONE; ident.b[4] = ONE; ident.b[8] = ONE;
        ident.path = PATH_INV;
        zero = '0;
        zero.path = PATH_ZERO;
        half = '0;
        half.b[0] = 32'h8000; half.b[4] = 32'h8000; half.b[8] = 32'h8000;
        half.path = PATH_INV;
        neg1 = '0;
        neg1.b[0] = -ONE; neg1.b[4] = -ONE; neg1.b[8] = -ONE;
        neg1.path = PATH_INV;
        xhalf = '0;
        xhalf.b[0] = 32'h8000; xhalf.b[8] = ONE;
        xhalf.path = PATH_XAXIS;
        yhalf = '0;
        yhalf.b[1] = 32'h8000; yhalf.b[8] = ONE;
        yhalf.path = PATH_YAXIS;

        directed.push_back(t_row'{mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1, ident});
        directed.push_back(t_row'{mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero});
        directed.push_back(t_row'{mat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                                  1'b1, zero});
        directed.push_back(t_row'{mat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                                  1'b1, zero});
        directed.push_back(t_row'{mat(2 * ONE, 0, 0, 0, 0, 0, 0, 0, ONE), 1'b1, xhalf});
        directed.push_back(t_row'{mat(0, 0, 0, 2 * ONE, 0, 0, 0, 0, ONE), 1'b1, yhalf});
        directed.push_back(t_row'{mat(2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE),
                                  1'b1, half});
        directed.push_back(t_row'{mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1'b1, neg1});
        // tiny diagonal: singular, no fallback since m22 is not one
        directed.push_back(t_row'{mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1, zero});
        // x axis with translation and rotation
        directed.push_back(t_row'{mat(3 * ONE, -ONE, 0, 0, 0, 0, 5 * ONE, -7 * ONE, ONE),
                                  1'b0, zero});
        // y axis with translation
        directed.push_back(t_row'{mat(0, 0, 0, -ONE, 3 * ONE, 0, 32'h8000_0000,
                                      32'h7FFF_FFFF, ONE), 1'b0, zero});
        // saturating positive and negative inverse entries
        directed.push_back(t_row'{mat(2, 0, 0, 0, 1 << 30, 0, 0, 0, 1 << 30), 1'b0, zero});
        directed.push_back(t_row'{mat(-2, 0, 0, 0, 1 << 30, 0, 0, 0, -(1 << 30)),
                                  1'b0, zero});
        // determinant exactly at the tolerance edge
        directed.push_back(t_row'{mat(32'h100, 0, 0, 0, 32'h100, 0, 0, 0, ONE), 1'b0, zero});
        // axis length below the floor: x fallback refused
        directed.push_back(t_row'{mat(1, 0, 0, 0, 0, 0, 0, 0, ONE), 1'b0, zero});
        // general rounding cases
        directed.push_back(t_row'{mat(3 * ONE, ONE, 0, ONE, 3 * ONE, 0, 7, -9, 3 * ONE),
                                  1'b0, zero});
        directed.push_back(t_row'{mat(ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE,
                                      5 * ONE, 6 * ONE, 0), 1'b0, zero});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            row = directed[k];
            send_matrix(row.m, row.typed ? row.exp : invert(row.m));
        end
        random_phase();

        // tolerance zero: only an exact zero determinant falls back
        write_reg(CFG_ZERO_TOL, 16'd0);
        write_reg(CFG_AXIS_FLOOR, 16'd0);
        write_reg(2'd2, 16'hFFFF);         // ignored index
        random_phase();

        write_reg(CFG_ZERO_TOL, 16'hFFFF);
        write_reg(CFG_AXIS_FLOOR, 16'hFFFF);
        write_reg(2'd3, 16'h0000);         // ignored index
        random_phase();

        write_reg(CFG_ZERO_TOL, 16'($urandom));
        write_reg(CFG_AXIS_FLOOR, 16'($urandom));
        random_phase();

        write_reg(CFG_ZERO_TOL, 16'($urandom_range(1, 64)));
        write_reg(CFG_AXIS_FLOOR, 16'($urandom_range(0, 64)));
        random_phase();

        if (mismatches == 0 && inverse_q.size() == 0) begin
            $display("affine3_matrix_inverse_test passed");
        end else begin
            $display("affine3_matrix_inverse_test failed");
        end
        $finish;
    end

endmodule
